// File: sv/kalman_track_filter_3axis_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis track filter
// Shared property forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KALMAN_TRACK_FILTER_3AXIS_ASSERT_SVH
`define KALMAN_TRACK_FILTER_3AXIS_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define KTF_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define KTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/ktf_pkg.sv
// ----------------------------------------------------------------------------
// ktf_pkg
// Types, constants and the sequencer program of the track filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ktf_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 33;
    localparam int PROD_W = 66;
    localparam int ACC_W  = 68;
    localparam int REG_W  = 31;
    localparam int STEP_W = 6;

    localparam logic [REG_W-1:0] DT_RESET = 31'd0;
    localparam logic [REG_W-1:0] SN_RESET = 31'd6554;
    localparam logic [REG_W-1:0] RN_RESET = 31'd65536;

    typedef enum logic [1:0] {
        CFG_TIME_STEP   = 2'd0,
        CFG_PROC_NOISE  = 2'd1,
        CFG_MEAS_NOISE  = 2'd2
    } t_cfg_idx;

    // First step of each program section.
    localparam logic [STEP_W-1:0] PRED_STEP      = 6'd0;
    localparam logic [STEP_W-1:0] PRED_AXIS_STEP = 6'd7;
    localparam logic [STEP_W-1:0] CORR_STEP      = 6'd18;

    typedef enum logic [4:0] {
        SRC_ONE, SRC_HALF, SRC_THIRD, SRC_DT, SRC_SN, SRC_RN,
        SRC_DT2, SRC_DT3, SRC_TA, SRC_Q00, SRC_Q01, SRC_Q11,
        SRC_X0, SRC_X1, SRC_P00, SRC_P01, SRC_P11, SRC_S00, SRC_S11,
        SRC_K00, SRC_K01, SRC_K10, SRC_K11, SRC_E0, SRC_E1, SRC_ZP, SRC_ZV
    } t_src;

    typedef enum logic [4:0] {
        DST_NONE, DST_DT2, DST_DT3, DST_TA, DST_Q00, DST_Q01, DST_Q11,
        DST_X0, DST_X1, DST_P00, DST_P01, DST_P11, DST_S00, DST_S11,
        DST_DET, DST_E0, DST_E1, DST_K00, DST_K01, DST_K10, DST_K11
    } t_dst;

    typedef enum logic [1:0] {
        ACT_NONE, ACT_DET, ACT_DIV, ACT_END
    } t_act;

    typedef struct packed {
        t_src a;
        t_src b;
        logic first;
        logic sub;
        logic rnd;
        logic tsat;
        logic dbl;
        t_dst dst;
        t_act act;
    } t_uop;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
        logic sub;
        logic rnd;
        logic tsat;
        logic dbl;
    } t_mac_ctl;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF);
        lo = -ACC_W'(64'sh8000_0000);
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

    function automatic t_uop mk(input t_src a, input t_src b, input logic first,
                                input logic sub, input logic rnd, input logic tsat,
                                input logic dbl, input t_dst dst, input t_act act);
        t_uop u;
        u.a = a; u.b = b; u.first = first; u.sub = sub; u.rnd = rnd;
        u.tsat = tsat; u.dbl = dbl; u.dst = dst; u.act = act;
        return u;
    endfunction

    // Program: predict constants, predict per axis, correct per axis.
    function automatic t_uop ktf_uop(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            6'd0:  u = mk(SRC_DT,  SRC_DT,    1, 0, 1, 0, 0, DST_DT2, ACT_NONE);
            6'd1:  u = mk(SRC_DT2, SRC_DT,    1, 0, 1, 0, 0, DST_DT3, ACT_NONE);
            6'd2:  u = mk(SRC_SN,  SRC_THIRD, 1, 0, 1, 0, 0, DST_TA,  ACT_NONE);
            6'd3:  u = mk(SRC_TA,  SRC_DT3,   1, 0, 1, 0, 0, DST_Q00, ACT_NONE);
            6'd4:  u = mk(SRC_SN,  SRC_HALF,  1, 0, 1, 0, 0, DST_TA,  ACT_NONE);
            6'd5:  u = mk(SRC_TA,  SRC_DT2,   1, 0, 1, 0, 0, DST_Q01, ACT_NONE);
            6'd6:  u = mk(SRC_SN,  SRC_DT,    1, 0, 1, 0, 0, DST_Q11, ACT_END);
            6'd7:  u = mk(SRC_X1,  SRC_DT,    1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd8:  u = mk(SRC_X0,  SRC_ONE,   0, 0, 1, 0, 0, DST_X0,  ACT_NONE);
            6'd9:  u = mk(SRC_P00, SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd10: u = mk(SRC_DT,  SRC_P01,   0, 0, 1, 1, 1, DST_NONE, ACT_NONE);
            6'd11: u = mk(SRC_DT2, SRC_P11,   0, 0, 1, 1, 0, DST_NONE, ACT_NONE);
            6'd12: u = mk(SRC_Q00, SRC_ONE,   0, 0, 1, 0, 0, DST_P00, ACT_NONE);
            6'd13: u = mk(SRC_P01, SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd14: u = mk(SRC_DT,  SRC_P11,   0, 0, 1, 1, 0, DST_NONE, ACT_NONE);
            6'd15: u = mk(SRC_Q01, SRC_ONE,   0, 0, 1, 0, 0, DST_P01, ACT_NONE);
            6'd16: u = mk(SRC_P11, SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd17: u = mk(SRC_Q11, SRC_ONE,   0, 0, 1, 0, 0, DST_P11, ACT_END);
            6'd18: u = mk(SRC_P00, SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd19: u = mk(SRC_RN,  SRC_ONE,   0, 0, 1, 0, 0, DST_S00, ACT_NONE);
            6'd20: u = mk(SRC_P11, SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd21: u = mk(SRC_RN,  SRC_ONE,   0, 0, 1, 0, 0, DST_S11, ACT_NONE);
            6'd22: u = mk(SRC_S00, SRC_S11,   1, 0, 0, 0, 0, DST_NONE, ACT_NONE);
            6'd23: u = mk(SRC_P01, SRC_P01,   0, 1, 0, 0, 0, DST_DET, ACT_DET);
            6'd24: u = mk(SRC_P00, SRC_S11,   1, 0, 0, 0, 0, DST_NONE, ACT_NONE);
            6'd25: u = mk(SRC_P01, SRC_P01,   0, 1, 0, 0, 0, DST_K00, ACT_DIV);
            6'd26: u = mk(SRC_P01, SRC_S00,   1, 0, 0, 0, 0, DST_NONE, ACT_NONE);
            6'd27: u = mk(SRC_P00, SRC_P01,   0, 1, 0, 0, 0, DST_K01, ACT_DIV);
            6'd28: u = mk(SRC_P01, SRC_S11,   1, 0, 0, 0, 0, DST_NONE, ACT_NONE);
            6'd29: u = mk(SRC_P11, SRC_P01,   0, 1, 0, 0, 0, DST_K10, ACT_DIV);
            6'd30: u = mk(SRC_P11, SRC_S00,   1, 0, 0, 0, 0, DST_NONE, ACT_NONE);
            6'd31: u = mk(SRC_P01, SRC_P01,   0, 1, 0, 0, 0, DST_K11, ACT_DIV);
            6'd32: u = mk(SRC_ZP,  SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd33: u = mk(SRC_X0,  SRC_ONE,   0, 1, 1, 0, 0, DST_E0,  ACT_NONE);
            6'd34: u = mk(SRC_ZV,  SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd35: u = mk(SRC_X1,  SRC_ONE,   0, 1, 1, 0, 0, DST_E1,  ACT_NONE);
            6'd36: u = mk(SRC_X0,  SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd37: u = mk(SRC_K00, SRC_E0,    0, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd38: u = mk(SRC_K01, SRC_E1,    0, 0, 1, 0, 0, DST_X0,  ACT_NONE);
            6'd39: u = mk(SRC_X1,  SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd40: u = mk(SRC_K10, SRC_E0,    0, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd41: u = mk(SRC_K11, SRC_E1,    0, 0, 1, 0, 0, DST_X1,  ACT_NONE);
            6'd42: u = mk(SRC_P00, SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd43: u = mk(SRC_K00, SRC_P00,   0, 1, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd44: u = mk(SRC_K01, SRC_P01,   0, 1, 1, 0, 0, DST_P00, ACT_NONE);
            6'd45: u = mk(SRC_P01, SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd46: u = mk(SRC_K00, SRC_P01,   0, 1, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd47: u = mk(SRC_K01, SRC_P11,   0, 1, 1, 0, 0, DST_P01, ACT_NONE);
            6'd48: u = mk(SRC_P11, SRC_ONE,   1, 0, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd49: u = mk(SRC_K10, SRC_P01,   0, 1, 1, 0, 0, DST_NONE, ACT_NONE);
            6'd50: u = mk(SRC_K11, SRC_P11,   0, 1, 1, 0, 0, DST_P11, ACT_END);
            default: u = mk(SRC_ONE, SRC_ONE, 1, 0, 1, 0, 0, DST_NONE, ACT_END);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// File: sv/ktf_mac.sv
// ----------------------------------------------------------------------------
// ktf_mac
// Shared multiply-accumulate unit: one registered product, then accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module ktf_mac #(
    parameter int FRAC_BITS = 16
) (
    input  wire                                   i_clk,
    input  wire ktf_pkg::t_mac_ctl                i_ctl,
    input  wire logic signed [ktf_pkg::OP_W-1:0]  i_a,
    input  wire logic signed [ktf_pkg::OP_W-1:0]  i_b,
    output logic signed [ktf_pkg::ACC_W-1:0]      o_acc,
    output logic signed [ktf_pkg::DATA_W-1:0]     o_sat
);

    localparam logic signed [ktf_pkg::PROD_W-1:0] HALF =
        ktf_pkg::PROD_W'(1) <<< (FRAC_BITS - 1);

    logic signed [ktf_pkg::PROD_W-1:0] r_prod;
    logic signed [ktf_pkg::ACC_W-1:0]  r_acc;
    logic signed [ktf_pkg::ACC_W-1:0]  n_acc;
    logic signed [ktf_pkg::PROD_W-1:0] w_rnd;
    logic signed [ktf_pkg::ACC_W-1:0]  w_term;

    // Rounding is half up: add one half, then an arithmetic shift floors.
    always_comb begin
        w_rnd = (r_prod + HALF) >>> FRAC_BITS;
        if (i_ctl.rnd) begin
            w_term = ktf_pkg::ACC_W'(w_rnd);
            if (i_ctl.tsat) begin
                w_term = ktf_pkg::ACC_W'(ktf_pkg::sat32(w_term));
            end
        end else begin
            w_term = ktf_pkg::ACC_W'(r_prod);
        end
        if (i_ctl.dbl) begin
            w_term = w_term <<< 1;
        end
        n_acc = (i_ctl.first ? '0 : r_acc) + (i_ctl.sub ? -w_term : w_term);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
    assign o_sat = ktf_pkg::sat32(r_acc);

endmodule

`default_nettype wire

// File: sv/ktf_div.sv
// ----------------------------------------------------------------------------
// ktf_div
// Serial restoring divider for the gain: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ktf_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire logic signed [63:0]    i_num,
    input  wire logic signed [63:0]    i_den,
    output logic                       o_done,
    output logic signed [ktf_pkg::DATA_W-1:0] o_quot
);

    localparam int INT_BITS = ktf_pkg::DATA_W - FRAC_BITS;
    localparam int Q_W      = ktf_pkg::DATA_W + 1;
    localparam int CNT_W    = $clog2(Q_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [63:0]       r_rem;
    logic [63:0]       r_den;
    logic [Q_W-1:0]    r_low;
    logic [Q_W-1:0]    r_q;
    logic              r_neg;
    logic signed [ktf_pkg::DATA_W-1:0] r_quot;

    logic [63:0] w_n;
    logic [63:0] w_d;
    logic [64:0] w_r2;
    logic [Q_W:0] w_mag;

    always_comb begin
        w_n   = i_num[63] ? (64'd0 - 64'(i_num)) : 64'(i_num);
        w_d   = i_den[63] ? (64'd0 - 64'(i_den)) : 64'(i_den);
        w_r2  = {r_rem, r_low[Q_W-1]};
        // The last quotient bit is the rounding bit.
        w_mag = ({1'b0, r_q} + (Q_W+1)'(1)) >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= i_num[63] ^ i_den[63];
                r_den <= w_d;
                if ((w_n >> INT_BITS) >= w_d) begin
                    r_quot <= (i_num[63] ^ i_den[63]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= w_n >> INT_BITS;
                    r_low  <= Q_W'(w_n[INT_BITS-1:0]) << (FRAC_BITS + 1);
                    r_q    <= '0;
                    r_cnt  <= CNT_W'(Q_W);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    if (w_r2 >= {1'b0, r_den}) begin
                        r_rem <= 64'(w_r2 - {1'b0, r_den});
                        r_q   <= {r_q[Q_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_r2[63:0];
                        r_q   <= {r_q[Q_W-2:0], 1'b0};
                    end
                    r_low <= r_low << 1;
                    r_cnt <= r_cnt - CNT_W'(1);
                end else begin
                    if (!r_neg) begin
                        r_quot <= (w_mag > (Q_W+1)'(34'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                                     : w_mag[31:0];
                    end else begin
                        r_quot <= (w_mag > (Q_W+1)'(34'h0_8000_0000)) ? 32'sh8000_0000
                                                                     : 32'(-w_mag);
                    end
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// File: sv/kalman_track_filter_3axis.sv
// ----------------------------------------------------------------------------
// kalman_track_filter_3axis
// Three constant-velocity Kalman filters (x, y, z) on one shared datapath.
// ----------------------------------------------------------------------------
// The input channel carries one beat per filter item: i_func selects predict
// (0) or correct (1), and the six measurement fields are used by correct only.
// A beat is taken when i_in_valid is high and o_in_stall is low. Each item
// returns one beat on the output channel with the six state estimates after
// the update; a beat leaves when o_out_valid is high and i_out_stall is low.
// Channel values are signed and register values unsigned fixed point, all with FRAC_BITS fraction bits.
// A small sequencer steps a program through one multiply-accumulate unit
// and a serial divider, axis by axis. Each multiply step passes the multiply
// and accumulate states, plus a write-back state when it writes a result.
// The four gain divisions per axis take most of the time of a correct item.
// A singular axis or a saturating gain shortens a correct item. Items do
// not overlap: the sequencer returns to idle before it takes the next one.
// o_in_stall is high while an item is at work. The finished result sits in
// an output register, so the next item is accepted while the receiver
// stalls; only its own delivery waits for that register to empty.
// Reset clears the state to zero, sets each covariance to identity and
// loads the register defaults. Register writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kalman_track_filter_3axis_assert.svh"

module kalman_track_filter_3axis #(
    parameter int FRAC_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [1:0]          i_cfg_index,
    input  wire [30:0]         i_cfg_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire                i_func,
    input  wire signed [31:0]  i_meas_x_pos,
    input  wire signed [31:0]  i_meas_x_vel,
    input  wire signed [31:0]  i_meas_y_pos,
    input  wire signed [31:0]  i_meas_y_vel,
    input  wire signed [31:0]  i_meas_z_pos,
    input  wire signed [31:0]  i_meas_z_vel,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [31:0] o_est_x_pos,
    output logic signed [31:0] o_est_x_vel,
    output logic signed [31:0] o_est_y_pos,
    output logic signed [31:0] o_est_y_vel,
    output logic signed [31:0] o_est_z_pos,
    output logic signed [31:0] o_est_z_vel
);

    localparam int OPW = ktf_pkg::OP_W;
    localparam int DW  = ktf_pkg::DATA_W;

    localparam logic signed [OPW-1:0] ONE_Q  = OPW'(1) <<< FRAC_BITS;
    localparam logic signed [OPW-1:0] HALF_Q = OPW'(1) <<< (FRAC_BITS - 1);
    localparam longint THIRD_L = ((64'sd3333 <<< FRAC_BITS) + 64'sd5000) / 64'sd10000;
    localparam logic signed [OPW-1:0] THIRD_Q = OPW'(THIRD_L);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_MUL, S_ACC, S_WB, S_DIV, S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [ktf_pkg::REG_W-1:0] r_dt;
    logic [ktf_pkg::REG_W-1:0] r_sn;
    logic [ktf_pkg::REG_W-1:0] r_rn;

    // Filter state, one entry per axis.
    logic signed [DW-1:0] r_pos [3];
    logic signed [DW-1:0] r_vel [3];
    logic signed [DW-1:0] r_p00 [3];
    logic signed [DW-1:0] r_p01 [3];
    logic signed [DW-1:0] r_p11 [3];

    // Item and per-axis working registers.
    logic                 r_func;
    logic signed [DW-1:0] r_zp [3];
    logic signed [DW-1:0] r_zv [3];
    logic [1:0]           r_axis;
    logic [ktf_pkg::STEP_W-1:0] r_step;
    logic signed [DW-1:0] r_dt2, r_dt3, r_ta, r_q00, r_q01, r_q11;
    logic signed [DW-1:0] r_wx0, r_wx1, r_w00, r_w01, r_w11;
    logic signed [DW-1:0] r_s00, r_s11;
    logic signed [DW-1:0] r_k00, r_k01, r_k10, r_k11;
    logic signed [OPW-1:0] r_e0, r_e1;
    logic signed [63:0]   r_det;

    // Output register.
    logic                 r_out_valid;
    logic signed [DW-1:0] r_est_pos [3];
    logic signed [DW-1:0] r_est_vel [3];

    ktf_pkg::t_uop     w_uop;
    ktf_pkg::t_mac_ctl w_mac_ctl;
    logic signed [OPW-1:0] w_a;
    logic signed [OPW-1:0] w_b;
    logic signed [ktf_pkg::ACC_W-1:0] w_acc;
    logic signed [DW-1:0] w_acc_sat;
    logic w_div_start;
    logic w_div_done;
    logic signed [DW-1:0] w_quot;
    logic w_in_take;
    logic w_last_axis;
    logic [ktf_pkg::STEP_W-1:0] w_axis_step;

    function automatic logic signed [OPW-1:0] sx(input logic signed [DW-1:0] v);
        return {v[DW-1], v};
    endfunction

    function automatic logic signed [OPW-1:0] operand(input ktf_pkg::t_src s);
        logic signed [OPW-1:0] v;
        case (s)
            ktf_pkg::SRC_ONE:   v = ONE_Q;
            ktf_pkg::SRC_HALF:  v = HALF_Q;
            ktf_pkg::SRC_THIRD: v = THIRD_Q;
            ktf_pkg::SRC_DT:    v = {2'b00, r_dt};
            ktf_pkg::SRC_SN:    v = {2'b00, r_sn};
            ktf_pkg::SRC_RN:    v = {2'b00, r_rn};
            ktf_pkg::SRC_DT2:   v = sx(r_dt2);
            ktf_pkg::SRC_DT3:   v = sx(r_dt3);
            ktf_pkg::SRC_TA:    v = sx(r_ta);
            ktf_pkg::SRC_Q00:   v = sx(r_q00);
            ktf_pkg::SRC_Q01:   v = sx(r_q01);
            ktf_pkg::SRC_Q11:   v = sx(r_q11);
            ktf_pkg::SRC_X0:    v = sx(r_wx0);
            ktf_pkg::SRC_X1:    v = sx(r_wx1);
            ktf_pkg::SRC_P00:   v = sx(r_w00);
            ktf_pkg::SRC_P01:   v = sx(r_w01);
            ktf_pkg::SRC_P11:   v = sx(r_w11);
            ktf_pkg::SRC_S00:   v = sx(r_s00);
            ktf_pkg::SRC_S11:   v = sx(r_s11);
            ktf_pkg::SRC_K00:   v = sx(r_k00);
            ktf_pkg::SRC_K01:   v = sx(r_k01);
            ktf_pkg::SRC_K10:   v = sx(r_k10);
            ktf_pkg::SRC_K11:   v = sx(r_k11);
            ktf_pkg::SRC_E0:    v = r_e0;
            ktf_pkg::SRC_E1:    v = r_e1;
            ktf_pkg::SRC_ZP:    v = sx(r_zp[r_axis]);
            ktf_pkg::SRC_ZV:    v = sx(r_zv[r_axis]);
            default:            v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_uop       = ktf_pkg::ktf_uop(r_step);
        w_a         = operand(w_uop.a);
        w_b         = operand(w_uop.b);
        w_mac_ctl   = '{mul_en: (r_state == S_MUL), acc_en: (r_state == S_ACC),
                        first: w_uop.first, sub: w_uop.sub, rnd: w_uop.rnd,
                        tsat: w_uop.tsat, dbl: w_uop.dbl};
        w_div_start = (r_state == S_WB) && (w_uop.act == ktf_pkg::ACT_DIV);
        w_in_take   = i_in_valid && (r_state == S_IDLE);
        w_last_axis = (r_axis == 2'd2);
        // The predict constants are done once; the loop then runs per axis.
        w_axis_step = r_func ? ktf_pkg::CORR_STEP : ktf_pkg::PRED_AXIS_STEP;
    end

    ktf_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac_ctl),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_acc (w_acc),
        .o_sat (w_acc_sat)
    );

    ktf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_acc[63:0]),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Configuration writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= ktf_pkg::DT_RESET;
            r_sn <= ktf_pkg::SN_RESET;
            r_rn <= ktf_pkg::RN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ktf_pkg::CFG_TIME_STEP:  r_dt <= i_cfg_data;
                ktf_pkg::CFG_PROC_NOISE: r_sn <= i_cfg_data;
                ktf_pkg::CFG_MEAS_NOISE: r_rn <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer, filter state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_axis      <= 2'd0;
            r_step      <= ktf_pkg::PRED_STEP;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_p00[i] <= DW'(ONE_Q);
                r_p01[i] <= '0;
                r_p11[i] <= DW'(ONE_Q);
            end
        end else begin
            // In the output state the register is refilled below instead.
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_func <= i_func;
                        r_zp[0] <= i_meas_x_pos;
                        r_zv[0] <= i_meas_x_vel;
                        r_zp[1] <= i_meas_y_pos;
                        r_zv[1] <= i_meas_y_vel;
                        r_zp[2] <= i_meas_z_pos;
                        r_zv[2] <= i_meas_z_vel;
                        r_axis  <= 2'd0;
                        r_step  <= i_func ? ktf_pkg::CORR_STEP : ktf_pkg::PRED_STEP;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_wx0   <= r_pos[r_axis];
                    r_wx1   <= r_vel[r_axis];
                    r_w00   <= r_p00[r_axis];
                    r_w01   <= r_p01[r_axis];
                    r_w11   <= r_p11[r_axis];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (w_uop.dst == ktf_pkg::DST_NONE && w_uop.act == ktf_pkg::ACT_NONE) begin
                        r_step  <= r_step + ktf_pkg::STEP_W'(1);
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    case (w_uop.dst)
                        ktf_pkg::DST_DT2: r_dt2 <= w_acc_sat;
                        ktf_pkg::DST_DT3: r_dt3 <= w_acc_sat;
                        ktf_pkg::DST_TA:  r_ta  <= w_acc_sat;
                        ktf_pkg::DST_Q00: r_q00 <= w_acc_sat;
                        ktf_pkg::DST_Q01: r_q01 <= w_acc_sat;
                        ktf_pkg::DST_Q11: r_q11 <= w_acc_sat;
                        ktf_pkg::DST_X0:  r_pos[r_axis] <= w_acc_sat;
                        ktf_pkg::DST_X1:  r_vel[r_axis] <= w_acc_sat;
                        ktf_pkg::DST_P00: r_p00[r_axis] <= w_acc_sat;
                        ktf_pkg::DST_P01: r_p01[r_axis] <= w_acc_sat;
                        ktf_pkg::DST_P11: r_p11[r_axis] <= w_acc_sat;
                        ktf_pkg::DST_S00: r_s00 <= w_acc_sat;
                        ktf_pkg::DST_S11: r_s11 <= w_acc_sat;
                        ktf_pkg::DST_DET: r_det <= w_acc[63:0];
                        ktf_pkg::DST_E0:  r_e0  <= w_acc[OPW-1:0];
                        ktf_pkg::DST_E1:  r_e1  <= w_acc[OPW-1:0];
                        default: ;
                    endcase
                    case (w_uop.act)
                        ktf_pkg::ACT_DIV: begin
                            r_state <= S_DIV;
                        end
                        ktf_pkg::ACT_DET, ktf_pkg::ACT_END: begin
                            // A singular innovation matrix leaves this axis as it is.
                            if (w_uop.act == ktf_pkg::ACT_END || w_acc == '0) begin
                                if (r_func ||
                                    r_step != ktf_pkg::PRED_AXIS_STEP - ktf_pkg::STEP_W'(1))
                                begin
                                    if (w_last_axis) begin
                                        r_state <= S_OUT;
                                    end else begin
                                        r_axis  <= r_axis + 2'd1;
                                        r_step  <= w_axis_step;
                                        r_state <= S_LOAD;
                                    end
                                end else begin
                                    r_step  <= ktf_pkg::PRED_AXIS_STEP;
                                    r_state <= S_MUL;
                                end
                            end else begin
                                r_step  <= r_step + ktf_pkg::STEP_W'(1);
                                r_state <= S_MUL;
                            end
                        end
                        default: begin
                            r_step  <= r_step + ktf_pkg::STEP_W'(1);
                            r_state <= S_MUL;
                        end
                    endcase
                end
                S_DIV: begin
                    if (w_div_done) begin
                        case (w_uop.dst)
                            ktf_pkg::DST_K00: r_k00 <= w_quot;
                            ktf_pkg::DST_K01: r_k01 <= w_quot;
                            ktf_pkg::DST_K10: r_k10 <= w_quot;
                            ktf_pkg::DST_K11: r_k11 <= w_quot;
                            default: ;
                        endcase
                        r_step  <= r_step + ktf_pkg::STEP_W'(1);
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        for (int i = 0; i < 3; i++) begin
                            r_est_pos[i] <= r_pos[i];
                            r_est_vel[i] <= r_vel[i];
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_est_x_pos = r_est_pos[0];
    assign o_est_x_vel = r_est_vel[0];
    assign o_est_y_pos = r_est_pos[1];
    assign o_est_y_vel = r_est_vel[1];
    assign o_est_z_pos = r_est_pos[2];
    assign o_est_z_vel = r_est_vel[2];

    // The axis counter only walks x, y and z.
    `KTF_ASSERT_ALWAYS(a_axis_range, i_clk, i_rst_n, r_axis != 2'd3, "axis counter out of range")
    // A result beat is raised only when the sequencer finishes an item.
    `KTF_ASSERT_IMP(a_out_from_seq, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state == S_OUT), "result raised outside the output state")
    // The divider answers only while the sequencer waits for it.
    `KTF_ASSERT_IMP(a_div_owned, i_clk, i_rst_n, w_div_done, r_state == S_DIV, "divider finished while not awaited")

endmodule

`default_nettype wire

// File: tb/kalman_track_filter_3axis_checker.sv
// ----------------------------------------------------------------------------
// Track filter result checker
// Watches the register port and both channels, keeps its own copy of the
// three axis filters and compares every output beat with the oldest estimate.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module kalman_track_filter_3axis_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_func,
    input  logic signed [31:0] i_meas_x_pos,
    input  logic signed [31:0] i_meas_x_vel,
    input  logic signed [31:0] i_meas_y_pos,
    input  logic signed [31:0] i_meas_y_vel,
    input  logic signed [31:0] i_meas_z_pos,
    input  logic signed [31:0] i_meas_z_vel,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_est_x_pos,
    input  logic signed [31:0] i_est_x_vel,
    input  logic signed [31:0] i_est_y_pos,
    input  logic signed [31:0] i_est_y_vel,
    input  logic signed [31:0] i_est_z_pos,
    input  logic signed [31:0] i_est_z_vel,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int FRAC = 16;

    typedef logic signed [127:0] wide_t;
    typedef logic [5:0][31:0] est_set_t;

    localparam wide_t HALF_Q  = wide_t'(1) <<< (FRAC - 1);
    localparam wide_t ONE_Q   = wide_t'(1) <<< FRAC;
    localparam wide_t THIRD_Q = ((wide_t'(3333) <<< FRAC) + 5000) / 10000;
    localparam wide_t S32_MAX = 128'sh7FFF_FFFF;
    localparam wide_t S32_MIN = -128'sh8000_0000;

    wide_t    trk[6];
    wide_t    cov[9];
    wide_t    dt_q, sn_q, rn_q;
    est_set_t est_queue[$];

    function automatic wide_t clamp32(input wide_t v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // Round half up, then floor: arithmetic shift on a signed value floors.
    function automatic wide_t rnd_q(input wide_t v);
        return (v + HALF_Q) >>> FRAC;
    endfunction

    function automatic wide_t qmul(input wide_t a, input wide_t b);
        return clamp32(rnd_q(a * b));
    endfunction

    // Gain entry num/det with FRAC fraction bits, half away from zero.
    function automatic wide_t gain_q(input wide_t num, input wide_t den);
        logic         neg;
        logic [127:0] n, d, q, r;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n % d;
        if (q >= (128'd1 << (32 - FRAC))) return neg ? S32_MIN : S32_MAX;
        for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 128'd1;
            end
        end
        r = r << 1;
        if (r >= d) q = q + 1;
        return clamp32(neg ? -wide_t'(q) : wide_t'(q));
    endfunction

    task automatic predict_axis(input int a);
        wide_t dt2, dt3, q00, q01, q11, p00, p01, p11;
        dt2 = qmul(dt_q, dt_q);
        dt3 = qmul(dt2, dt_q);
        q00 = qmul(qmul(sn_q, THIRD_Q), dt3);
        q01 = qmul(qmul(sn_q, HALF_Q), dt2);
        q11 = qmul(sn_q, dt_q);
        p00 = cov[3*a];
        p01 = cov[3*a+1];
        p11 = cov[3*a+2];
        trk[2*a]   = clamp32(trk[2*a] + rnd_q(trk[2*a+1] * dt_q));
        cov[3*a]   = clamp32(p00 + 2 * qmul(dt_q, p01) + qmul(dt2, p11) + q00);
        cov[3*a+1] = clamp32(p01 + qmul(dt_q, p11) + q01);
        cov[3*a+2] = clamp32(p11 + q11);
    endtask

    task automatic correct_axis(input int a, input wide_t zp, input wide_t zv);
        wide_t p00, p01, p11, s00, s11, det, k00, k01, k10, k11, e0, e1;
        p00 = cov[3*a];
        p01 = cov[3*a+1];
        p11 = cov[3*a+2];
        s00 = clamp32(p00 + rn_q);
        s11 = clamp32(p11 + rn_q);
        det = s00 * s11 - p01 * p01;
        // A singular innovation matrix means zero gain: nothing moves.
        if (det == 0) return;
        k00 = gain_q(p00 * s11 - p01 * p01, det);
        k01 = gain_q(p01 * s00 - p00 * p01, det);
        k10 = gain_q(p01 * s11 - p11 * p01, det);
        k11 = gain_q(p11 * s00 - p01 * p01, det);
        e0 = zp - trk[2*a];
        e1 = zv - trk[2*a+1];
        trk[2*a]   = clamp32(trk[2*a] + rnd_q(k00 * e0) + rnd_q(k01 * e1));
        trk[2*a+1] = clamp32(trk[2*a+1] + rnd_q(k10 * e0) + rnd_q(k11 * e1));
        cov[3*a]   = clamp32(p00 - rnd_q(k00 * p00) - rnd_q(k01 * p01));
        cov[3*a+1] = clamp32(p01 - rnd_q(k00 * p01) - rnd_q(k01 * p11));
        cov[3*a+2] = clamp32(p11 - rnd_q(k10 * p01) - rnd_q(k11 * p11));
    endtask

    task automatic report(input string what);
        if (o_errors < 40) $display("ERROR @%0t: %s", $realtime, what);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        est_set_t e, got;
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) trk[i] = 0;
            for (int a = 0; a < 3; a++) begin
                cov[3*a]   = ONE_Q;
                cov[3*a+1] = 0;
                cov[3*a+2] = ONE_Q;
            end
            dt_q = wide_t'(ktf_pkg::DT_RESET);
            sn_q = wide_t'(ktf_pkg::SN_RESET);
            rn_q = wide_t'(ktf_pkg::RN_RESET);
            est_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ktf_pkg::CFG_TIME_STEP:  dt_q = wide_t'(i_cfg_data);
                    ktf_pkg::CFG_PROC_NOISE: sn_q = wide_t'(i_cfg_data);
                    ktf_pkg::CFG_MEAS_NOISE: rn_q = wide_t'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func) begin
                    correct_axis(0, wide_t'(i_meas_x_pos), wide_t'(i_meas_x_vel));
                    correct_axis(1, wide_t'(i_meas_y_pos), wide_t'(i_meas_y_vel));
                    correct_axis(2, wide_t'(i_meas_z_pos), wide_t'(i_meas_z_vel));
                end else begin
                    for (int a = 0; a < 3; a++) predict_axis(a);
                end
                for (int i = 0; i < 6; i++) e[i] = trk[i][31:0];
                est_queue.push_back(e);
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_est_z_vel, i_est_z_pos, i_est_y_vel, i_est_y_pos,
                       i_est_x_vel, i_est_x_pos};
                if (est_queue.size() == 0) begin
                    report("output beat with no estimate waiting");
                end else begin
                    e = est_queue.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (got[i] !== e[i])
                            report($sformatf("estimate field %0d: got %h, expected %h",
                                             i, got[i], e[i]));
                    end
                end
            end
        end
        o_pending = est_queue.size();
    end

    initial o_errors = 0;

endmodule

// File: tb/tb_kalman_track_filter_3axis.sv
// ----------------------------------------------------------------------------
// Track filter testbench
// Drives predict and correct beats under several register settings, with
// bursty input, a patterned output stall and one long hold-off; a checker
// beside the block predicts and compares every estimate.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_kalman_track_filter_3axis;

    // The register index is two bits wide; index three selects nothing and a
    // write to it must be ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_CORRECT = 1'b1;
    localparam logic [30:0] REG_MAX = 31'h7FFF_FFFF;

    typedef logic [5:0][31:0] meas_set_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic signed [31:0] m_xp, m_xv, m_yp, m_yv, m_zp, m_zv;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] e_xp, e_xv, e_yp, e_yv, e_zp, e_zv;
    int                 errors;
    int                 pending;
    int                 burst_left;

    kalman_track_filter_3axis dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_func(func),
        .i_meas_x_pos(m_xp), .i_meas_x_vel(m_xv), .i_meas_y_pos(m_yp),
        .i_meas_y_vel(m_yv), .i_meas_z_pos(m_zp), .i_meas_z_vel(m_zv),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_est_x_pos(e_xp), .o_est_x_vel(e_xv), .o_est_y_pos(e_yp),
        .o_est_y_vel(e_yv), .o_est_z_pos(e_zp), .o_est_z_vel(e_zv)
    );

    kalman_track_filter_3axis_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_func(func),
        .i_meas_x_pos(m_xp), .i_meas_x_vel(m_xv), .i_meas_y_pos(m_yp),
        .i_meas_y_vel(m_yv), .i_meas_z_pos(m_zp), .i_meas_z_vel(m_zv),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_est_x_pos(e_xp), .i_est_x_vel(e_xv), .i_est_y_pos(e_yp),
        .i_est_y_vel(e_yv), .i_est_z_pos(e_zp), .i_est_z_vel(e_zv),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs. The slowest correct run is well
    // under a third of this.
    initial begin
        #30ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Output stall: segments of varied pressure. Once, early on, the receiver
    // holds off for a long stretch so the result register fills, the next item
    // finishes behind it and the input channel has to stall.
    initial begin
        int mode, pct;
        out_stall = 1'b0;
        @(posedge clk iff rst_n);
        repeat (3000) @(posedge clk);
        out_stall <= 1'b1;
        repeat (4000) @(posedge clk);
        forever begin
            mode = $urandom_range(0, 3);
            pct = (mode == 0) ? 0 : (mode == 1) ? 30 : (mode == 2) ? 70 : 95;
            repeat ($urandom_range(20, 400)) begin
                out_stall <= ($urandom_range(1, 100) <= pct);
                @(posedge clk);
            end
        end
    end

    // Register write: one cycle with the enable high, then the enable drops again before the task returns.
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [30:0] dt, input logic [30:0] sn,
                            input logic [30:0] rn);
        write_reg(ktf_pkg::CFG_TIME_STEP, dt);
        write_reg(ktf_pkg::CFG_PROC_NOISE, sn);
        write_reg(ktf_pkg::CFG_MEAS_NOISE, rn);
    endtask

    // One input beat. Bursts keep valid high from beat to beat; between
    // bursts valid drops for a random gap, which may be empty.
    task automatic send_beat(input logic f, input meas_set_t m);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        func <= f;
        {m_zv, m_zp, m_yv, m_yp, m_xv, m_xp} <= m;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    // Drop valid, then wait until every estimate has come back. Every item
    // yields a result, so the block is idle once the last one has left.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    function automatic meas_set_t fill(input logic [31:0] v);
        meas_set_t m;
        for (int i = 0; i < 6; i++) m[i] = v;
        return m;
    endfunction

    // Mostly measurements near the origin, where the tracks live; now and
    // then a full 32-bit pattern so every bit toggles.
    function automatic meas_set_t rand_meas();
        meas_set_t m;
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(0, 5) == 0) m[i] = $urandom;
            else m[i] = 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
        end
        return m;
    endfunction

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            // Mostly a predict followed by a correct, as a tracker runs.
            if ($urandom_range(0, 9) < 8) begin
                send_beat(FUNC_PREDICT, rand_meas());
                send_beat(FUNC_CORRECT, rand_meas());
                n++;
            end else begin
                send_beat(1'($urandom_range(0, 1)), rand_meas());
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ktf_pkg::CFG_TIME_STEP;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_PREDICT;
        {m_zv, m_zp, m_yv, m_yp, m_xv, m_xp} = '0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: register defaults, field extremes, both operations.
        send_beat(FUNC_PREDICT, fill(32'h0));
        send_beat(FUNC_CORRECT, fill(32'h7FFF_FFFF));
        send_beat(FUNC_CORRECT, fill(32'h8000_0000));
        send_beat(FUNC_CORRECT, fill(32'h0));
        send_beat(FUNC_CORRECT, fill(32'hFFFF_FFFF));
        send_beat(FUNC_PREDICT, fill(32'h5555_AAAA));
        drain();
        set_regs(31'd65536, 31'd6554, 31'd65536);
        write_reg(CFG_UNUSED, REG_MAX);
        send_beat(FUNC_CORRECT, {32'h0001_0000, 32'h0003_0000, 32'hFFFF_0000,
                                 32'hFFFE_8000, 32'h0000_8000, 32'h0001_8000});
        send_beat(FUNC_PREDICT, fill(32'h0));
        send_beat(FUNC_PREDICT, fill(32'h0));
        send_beat(FUNC_CORRECT, fill(32'h0002_0000));
        send_beat(FUNC_PREDICT, fill(32'h0));
        drain();
        // Smallest noise: the correction trusts the measurement almost fully.
        set_regs(31'd0, 31'd0, 31'd1);
        send_beat(FUNC_CORRECT, fill(32'h1234_5678));
        send_beat(FUNC_PREDICT, fill(32'h0));
        send_beat(FUNC_CORRECT, fill(32'hEDCB_A988));
        drain();

        // Random phases under several register settings.
        set_regs(31'd6554, 31'd6554, 31'd65536);
        random_phase(150);
        drain();
        set_regs(31'($urandom_range(0, 1 << 17)), 31'($urandom_range(0, 1 << 18)),
                 31'($urandom_range(1, 1 << 20)));
        random_phase(150);
        drain();
        set_regs(31'd0, 31'd0, 31'd1);
        random_phase(120);
        drain();
        set_regs(31'd65536, 31'(1 << 24), REG_MAX);
        random_phase(150);
        drain();
        set_regs(31'($urandom_range(1, 1 << 16)), 31'($urandom_range(1, 1 << 16)),
                 31'($urandom_range(1 << 12, 1 << 18)));
        random_phase(200);
        drain();

        // Largest time step and process noise: the covariance saturates, the
        // innovation matrix becomes singular and the gain drops to zero.
        set_regs(REG_MAX, REG_MAX, 31'd1);
        send_beat(FUNC_PREDICT, fill(32'h0));
        send_beat(FUNC_PREDICT, fill(32'h0));
        send_beat(FUNC_PREDICT, fill(32'h0));
        send_beat(FUNC_CORRECT, fill(32'h7FFF_FFFF));
        send_beat(FUNC_CORRECT, fill(32'h8000_0000));
        random_phase(20);
        drain();

        repeat (100) @(posedge clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/ktf_pkg.sv
sv/ktf_mac.sv
sv/ktf_div.sv
sv/kalman_track_filter_3axis.sv
tb/kalman_track_filter_3axis_checker.sv
tb/tb_kalman_track_filter_3axis.sv
